[hw/rtl/i2cmbt_pkg.sv]
`timescale 1ns / 1ps
// Shared types for the single-byte I2C master: request and result payloads
// and the one-hot phase encoding. No dependencies.

package i2cmbt_pkg;

  localparam logic [0:0] KindTick    = 1'b0;
  localparam logic [0:0] KindCommand = 1'b1;

  localparam logic [2:0] BitMsb = 3'd7;
  localparam logic [2:0] BitLsb = 3'd0;

  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic [6:0] target_address;
    logic [7:0] write_byte;
    logic       sda_in;
  } i2c_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } i2c_out_t;

  typedef enum logic [15:0] {
    PH_IDLE     = 16'h0001,
    PH_ADDR_LO  = 16'h0002,
    PH_ADDR_HI  = 16'h0004,
    PH_AACK_LO  = 16'h0008,
    PH_AACK_HI  = 16'h0010,
    PH_WR_LO    = 16'h0020,
    PH_WR_HI    = 16'h0040,
    PH_RD_LO    = 16'h0080,
    PH_RD_HI    = 16'h0100,
    PH_DACK_LO  = 16'h0200,
    PH_DACK_HI  = 16'h0400,
    PH_NACK_LO  = 16'h0800,
    PH_NACK_HI  = 16'h1000,
    PH_STOP_LO  = 16'h2000,
    PH_STOP_HI  = 16'h4000,
    PH_STOP_END = 16'h8000
  } phase_e;

endpackage

[hw/rtl/i2c_master_byte_transfer.sv]
`timescale 1ns / 1ps
// Single-byte I2C master, one half SCL period per tick request.
// Depends on i2cmbt_pkg for payload structs and the phase encoding.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------
//   in      | in_valid_i / in_stall_o | in_data_i  (i2c_in_t)
//   out     | out_valid_o/ out_stall_i| out_data_o (i2c_out_t)
//
// One request per cycle while in_stall_o is low: the bus FSM updates at the edge that accepts a
// request and the result lands in the output register on that same edge.
// The output register is the only buffer.
// in_stall_o is high only while the output register is full and stalled.
// Reset leaves the bus released (SCL and SDA high), the FSM idle and no
// result pending.

module i2c_master_byte_transfer
  import i2cmbt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  i2c_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output i2c_out_t out_data_o
);

  phase_e     phase_q, phase_d;
  logic [2:0] bit_idx_q, bit_idx_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] pending_q, pending_d;
  logic       read_flag_q, read_flag_d;
  logic [7:0] recv_q, recv_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       done;

  logic       out_valid_q, out_valid_d;
  i2c_out_t   out_data_q, out_data_d;

  logic       in_acc;
  logic       cur_bit;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign cur_bit    = shift_q[bit_idx_q];

  always_comb begin
    phase_d     = phase_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    pending_d   = pending_q;
    read_flag_d = read_flag_q;
    recv_d      = recv_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    done        = 1'b0;

    if (in_data_i.kind == KindCommand) begin
      // Start condition: SDA low while SCL is still high. Busy commands drop.
      if (phase_q == PH_IDLE) begin
        shift_d     = {in_data_i.target_address, in_data_i.is_read};
        pending_d   = in_data_i.write_byte;
        read_flag_d = in_data_i.is_read;
        bit_idx_d   = BitMsb;
        scl_d       = 1'b1;
        sda_d       = 1'b0;
        phase_d     = PH_ADDR_LO;
      end
    end else begin
      unique case (phase_q)
        PH_ADDR_LO, PH_WR_LO: begin
          scl_d   = 1'b0;
          sda_d   = cur_bit;
          phase_d = (phase_q == PH_ADDR_LO) ? PH_ADDR_HI : PH_WR_HI;
        end
        PH_ADDR_HI, PH_WR_HI: begin
          scl_d = 1'b1;
          if (bit_idx_q == BitLsb) begin
            phase_d = (phase_q == PH_ADDR_HI) ? PH_AACK_LO : PH_DACK_LO;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            phase_d   = (phase_q == PH_ADDR_HI) ? PH_ADDR_LO : PH_WR_LO;
          end
        end
        PH_AACK_LO: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          phase_d = PH_AACK_HI;
        end
        PH_DACK_LO: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          phase_d = PH_DACK_HI;
        end
        PH_RD_LO: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          phase_d = PH_RD_HI;
        end
        PH_NACK_LO: begin
          scl_d   = 1'b0;
          sda_d   = 1'b1;
          phase_d = PH_NACK_HI;
        end
        PH_AACK_HI: begin
          // Hold SCL low until the target pulls SDA down.
          if (!in_data_i.sda_in) begin
            scl_d     = 1'b1;
            bit_idx_d = BitMsb;
            if (read_flag_q) begin
              shift_d = '0;
              phase_d = PH_RD_LO;
            end else begin
              shift_d = pending_q;
              phase_d = PH_WR_LO;
            end
          end
        end
        PH_RD_HI: begin
          scl_d = 1'b1;
          if (in_data_i.sda_in) begin
            shift_d[bit_idx_q] = 1'b1;
          end
          if (bit_idx_q == BitLsb) begin
            recv_d  = shift_d;
            phase_d = PH_NACK_LO;
          end else begin
            bit_idx_d = bit_idx_q - 3'd1;
            phase_d   = PH_RD_LO;
          end
        end
        PH_DACK_HI: begin
          if (!in_data_i.sda_in) begin
            scl_d   = 1'b1;
            phase_d = PH_STOP_LO;
          end
        end
        PH_NACK_HI: begin
          scl_d   = 1'b1;
          phase_d = PH_STOP_LO;
        end
        PH_STOP_LO: begin
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = PH_STOP_HI;
        end
        PH_STOP_HI: begin
          scl_d   = 1'b1;
          phase_d = PH_STOP_END;
        end
        PH_STOP_END: begin
          sda_d   = 1'b1;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (in_acc) begin
      out_valid_d            = 1'b1;
      out_data_d.scl_level   = scl_d;
      out_data_d.sda_release = sda_d;
      out_data_d.busy_res    = (phase_d != PH_IDLE);
      out_data_d.done_res    = done;
      out_data_d.read_byte   = recv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_idx_q   <= '0;
      shift_q     <= '0;
      pending_q   <= '0;
      read_flag_q <= 1'b0;
      recv_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q     <= phase_d;
        bit_idx_q   <= bit_idx_d;
        shift_q     <= shift_d;
        pending_q   <= pending_d;
        read_flag_q <= read_flag_d;
        recv_q      <= recv_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_idle_bus_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (scl_q && sda_q))
    else $error("bus not released while idle");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  a_stop_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.kind == KindTick) && (phase_q == PH_STOP_END))
      |=> (out_valid_q && out_data_q.done_res && (phase_q == PH_IDLE)))
    else $error("stop phase did not complete the transaction");

  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_acc) |-> (out_data_q.busy_res == (phase_q != PH_IDLE)))
    else $error("busy flag disagrees with the bus phase");
`endif

endmodule

[tb/sv/i2c_master_byte_transfer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the single-byte I2C master: drives tick and command requests
// through a valid/stall handshake and checks every result against a cycle-free bus predictor.
// Depends on i2cmbt_pkg and the i2c_master_byte_transfer RTL.

module i2c_master_byte_transfer_tb;
  import i2cmbt_pkg::*;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  i2c_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  i2c_out_t out_data_o;

  // Bus predictor state
  phase_e      bus_phase;
  logic [2:0]  bit_pos;
  logic [7:0]  shifter;
  logic [7:0]  wr_data;
  logic [7:0]  rx_byte;
  logic        rd_mode;
  logic        scl_q;
  logic        sda_q;
  logic        req_ignored;

  i2c_out_t    expected_levels[$];
  int unsigned bus_steps_taken = 0;
  int unsigned mismatch_count  = 0;
  int unsigned send_gap_pct    = 0;
  int unsigned recv_stall_pct  = 0;

  i2c_master_byte_transfer u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Work out the bus levels after one request and advance the predictor state.
  function automatic i2c_out_t predict_bus_levels(input i2c_in_t req);
    i2c_out_t res;
    logic     stop_done;
    stop_done   = 1'b0;
    req_ignored = 1'b0;
    if (req.kind == KindCommand) begin
      if (bus_phase == PH_IDLE) begin
        shifter   = {req.target_address, req.is_read};
        wr_data   = req.write_byte;
        rd_mode   = req.is_read;
        bit_pos   = BitMsb;
        scl_q     = 1'b1;
        sda_q     = 1'b0;
        bus_phase = PH_ADDR_LO;
      end else begin
        req_ignored = 1'b1;
      end
    end else begin
      case (bus_phase)
        PH_IDLE: begin
          req_ignored = 1'b1;
        end
        PH_ADDR_LO, PH_WR_LO: begin
          scl_q     = 1'b0;
          sda_q     = shifter[bit_pos];
          // one-hot encoding: the high half of a bit is the next phase up
          bus_phase = phase_e'(bus_phase << 1);
        end
        PH_ADDR_HI, PH_WR_HI: begin
          scl_q = 1'b1;
          if (bit_pos == BitLsb) begin
            bus_phase = (bus_phase == PH_ADDR_HI) ? PH_AACK_LO : PH_DACK_LO;
          end else begin
            bit_pos   = bit_pos - 3'd1;
            bus_phase = phase_e'(bus_phase >> 1);
          end
        end
        PH_AACK_LO, PH_DACK_LO, PH_RD_LO, PH_NACK_LO: begin
          scl_q     = 1'b0;
          sda_q     = 1'b1;
          bus_phase = phase_e'(bus_phase << 1);
        end
        PH_AACK_HI: begin
          // hold SCL low until the target pulls SDA down
          if (!req.sda_in) begin
            scl_q   = 1'b1;
            bit_pos = BitMsb;
            if (rd_mode) begin
              shifter   = 8'h00;
              bus_phase = PH_RD_LO;
            end else begin
              shifter   = wr_data;
              bus_phase = PH_WR_LO;
            end
          end
        end
        PH_RD_HI: begin
          scl_q = 1'b1;
          if (req.sda_in) shifter[bit_pos] = 1'b1;
          if (bit_pos == BitLsb) begin
            rx_byte   = shifter;
            bus_phase = PH_NACK_LO;
          end else begin
            bit_pos   = bit_pos - 3'd1;
            bus_phase = PH_RD_LO;
          end
        end
        PH_DACK_HI: begin
          if (!req.sda_in) begin
            scl_q     = 1'b1;
            bus_phase = PH_STOP_LO;
          end
        end
        PH_NACK_HI: begin
          scl_q     = 1'b1;
          bus_phase = PH_STOP_LO;
        end
        PH_STOP_LO: begin
          scl_q     = 1'b0;
          sda_q     = 1'b0;
          bus_phase = PH_STOP_HI;
        end
        PH_STOP_HI: begin
          scl_q     = 1'b1;
          bus_phase = PH_STOP_END;
        end
        PH_STOP_END: begin
          sda_q     = 1'b1;
          bus_phase = PH_IDLE;
          stop_done = 1'b1;
        end
        default: ;
      endcase
    end
    res.scl_level   = scl_q;
    res.sda_release = sda_q;
    res.busy_res    = (bus_phase != PH_IDLE);
    res.done_res    = stop_done;
    res.read_byte   = rx_byte;
    return res;
  endfunction

  task automatic send_request(input i2c_in_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_levels.push_back(predict_bus_levels(req));
    if (!req_ignored) bus_steps_taken++;
  endtask

  // Command fields on a tick are don't-care: fill them at random.
  task automatic send_tick(input logic sda);
    i2c_in_t req;
    req.kind           = KindTick;
    req.is_read        = 1'($urandom_range(1));
    req.target_address = 7'($urandom_range(127));
    req.write_byte     = 8'($urandom_range(255));
    req.sda_in         = sda;
    send_request(req);
  endtask

  task automatic send_command(input logic rd, input logic [6:0] addr, input logic [7:0] data);
    i2c_in_t req;
    req.kind           = KindCommand;
    req.is_read        = rd;
    req.target_address = addr;
    req.write_byte     = data;
    req.sda_in         = 1'($urandom_range(1));
    send_request(req);
  endtask

  // Tick the bus until the stop completes, acting as the target on SDA.
  task automatic finish_transaction(input int unsigned hold_min, input int unsigned hold_max,
                                    input int unsigned noise_pct);
    int unsigned holds_left;
    holds_left = $urandom_range(hold_max, hold_min);
    while (bus_phase != PH_IDLE) begin
      if ($urandom_range(99) < noise_pct) begin
        send_command(1'($urandom_range(1)), 7'($urandom_range(127)),
                     8'($urandom_range(255)));
      end else if (bus_phase == PH_AACK_HI || bus_phase == PH_DACK_HI) begin
        if (holds_left != 0) begin
          holds_left--;
          send_tick(1'b1);
        end else begin
          send_tick(1'b0);
          holds_left = $urandom_range(hold_max, hold_min);
        end
      end else begin
        send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_idle_requests();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Read from the top address, retry a command mid-flight and stretch the address ack.
  task automatic test_read_with_ack_stretch();
    send_command(1'b1, 7'h7F, 8'h00);
    send_command(1'b0, 7'h00, 8'hFF);
    finish_transaction(2, 2, 0);
  endtask

  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned steps);
    int unsigned first_step;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    first_step     = bus_steps_taken;
    while (bus_steps_taken - first_step < steps) begin
      if ($urandom_range(99) < 90) begin
        send_command(1'($urandom_range(1)), 7'($urandom_range(127)),
                     8'($urandom_range(255)));
        finish_transaction(0, ($urandom_range(3) == 0) ? 3 : 0, 3);
      end else begin
        send_tick(1'($urandom_range(1)));
      end
    end
    drain_results();
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    i2c_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        want = expected_levels.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_data_o.scl_level));
        check_field("sda_release", 8'(want.sda_release), 8'(out_data_o.sda_release));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data_o.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data_o.done_res));
        check_field("read_byte", want.read_byte, out_data_o.read_byte);
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    bus_phase   = PH_IDLE;
    bit_pos     = 3'd0;
    shifter     = 8'h00;
    wr_data     = 8'h00;
    rx_byte     = 8'h00;
    rd_mode     = 1'b0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
    req_ignored = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct   = 9;
    recv_stall_pct = 81;
    test_idle_requests();
    test_read_with_ack_stretch();
    test_random_traffic(9, 81, 300);
    test_random_traffic(81, 9, 300);
    test_random_traffic(0, 0, 300);

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
